// ===== sv/segx_pkg.sv =====
// Shared constants for the segment intersection test.
package segx_pkg;

   // Register stages between an accepted word and its result strobe.
   localparam int unsigned PIPE_DEPTH = 4;

   // Endpoint tests, in a fixed order: C and D against AB, then A and B against CD.
   localparam int unsigned NUM_TESTS = 4;

endpackage

// ===== sv/segment_intersection_test.sv =====
// Pipelined test of whether two grid-coordinate line segments intersect.
//
// This block takes one pair of segments, AB and CD, per clock as a request word.
// It returns one response word with a single flag that says whether the two
// segments intersect. The flag is set in either of two cases:
// - an endpoint of one segment is collinear with the other segment and lies
//   strictly inside it;
// - C and D lie on opposite sides of AB, and A and B lie on opposite sides of CD.
// For the side test, "left" means a cross product strictly greater than zero.
// A point on the line counts as not left.
//
// All arithmetic is exact two's-complement integer arithmetic, so no rounding
// takes place. Each coordinate port is COORD_BITS wide, with a valid range of
// 4 to 30.
//
// A word is accepted on every clock edge at which start is high. Busy is
// always low, because the pipeline never holds anything off. The response
// passes through the four register stages below. It is on rsp_intersects for
// one cycle, marked by rsp_valid. The receiver must take it in that cycle. The
// sustained rate is one word per clock.
//
// The four register stages are:
// - stage 1 forms the edge vectors and the endpoint offsets;
// - stage 2 forms the twenty signed products, each at most 31 by 31 bits;
// - stage 3 sums them into four cross products, four dot products and two
//   squared lengths;
// - stage 4 makes the compares and drives the response register.
// Valid bits travel with the data and are cleared by the synchronous reset.
// The pipeline holds no other state.
module segment_intersection_test
   import segx_pkg::*;
#(
   parameter int unsigned COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by_coord,
   input  logic signed [COORD_BITS-1:0] req_cx,
   input  logic signed [COORD_BITS-1:0] req_cy,
   input  logic signed [COORD_BITS-1:0] req_dx,
   input  logic signed [COORD_BITS-1:0] req_dy,
   output logic                         rsp_valid,
   output logic                         rsp_intersects
);

   // Differences need one extra bit, and products double that width.
   // A sum of two products needs one more bit again.
   localparam int unsigned DW = COORD_BITS + 1;
   localparam int unsigned PW = 2 * DW;
   localparam int unsigned SW = PW + 1;

   // Stage 1: the edge vectors, and the offset of each tested point from the
   // start of the segment that it is tested against.
   logic                 v1_ff, v1_in;
   logic signed [DW-1:0] e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [DW-1:0] e1x_in, e1y_in, e2x_in, e2y_in;
   logic signed [DW-1:0] pvx_ff [NUM_TESTS];
   logic signed [DW-1:0] pvy_ff [NUM_TESTS];
   logic signed [DW-1:0] pvx_in [NUM_TESTS];
   logic signed [DW-1:0] pvy_in [NUM_TESTS];

   // Stage 2: the products.
   logic                 v2_ff, v2_in;
   logic signed [PW-1:0] cpa_ff [NUM_TESTS];
   logic signed [PW-1:0] cpb_ff [NUM_TESTS];
   logic signed [PW-1:0] dpa_ff [NUM_TESTS];
   logic signed [PW-1:0] dpb_ff [NUM_TESTS];
   logic signed [PW-1:0] cpa_in [NUM_TESTS];
   logic signed [PW-1:0] cpb_in [NUM_TESTS];
   logic signed [PW-1:0] dpa_in [NUM_TESTS];
   logic signed [PW-1:0] dpb_in [NUM_TESTS];
   logic signed [PW-1:0] l1a_ff, l1b_ff, l2a_ff, l2b_ff;
   logic signed [PW-1:0] l1a_in, l1b_in, l2a_in, l2b_in;

   // Stage 3: the cross products, the dot products and the squared lengths.
   logic                 v3_ff, v3_in;
   logic signed [SW-1:0] cross_ff [NUM_TESTS];
   logic signed [SW-1:0] dot_ff   [NUM_TESTS];
   logic signed [SW-1:0] cross_in [NUM_TESTS];
   logic signed [SW-1:0] dot_in   [NUM_TESTS];
   logic signed [SW-1:0] len1_ff, len2_ff, len1_in, len2_in;

   // Stage 4: the response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;

   // Per-test flags in the compare stage.
   logic [NUM_TESTS-1:0] left_flag;
   logic [NUM_TESTS-1:0] between_flag;

   assign busy = 1'b0;

   always_comb begin
      v1_in  = start;
      e1x_in = DW'(req_bx) - DW'(req_ax);
      e1y_in = DW'(req_by_coord) - DW'(req_ay);
      e2x_in = DW'(req_dx) - DW'(req_cx);
      e2y_in = DW'(req_dy) - DW'(req_cy);
      // C and D are offset from A, and A and B are offset from C.
      pvx_in[0] = DW'(req_cx) - DW'(req_ax);
      pvy_in[0] = DW'(req_cy) - DW'(req_ay);
      pvx_in[1] = DW'(req_dx) - DW'(req_ax);
      pvy_in[1] = DW'(req_dy) - DW'(req_ay);
      pvx_in[2] = DW'(req_ax) - DW'(req_cx);
      pvy_in[2] = DW'(req_ay) - DW'(req_cy);
      pvx_in[3] = DW'(req_bx) - DW'(req_cx);
      pvy_in[3] = DW'(req_by_coord) - DW'(req_cy);
   end

   always_comb begin
      v2_in = v1_ff;
      for (int k = 0; k < NUM_TESTS; k++) begin
         // The first two tests run against AB, and the last two against CD.
         if (k < 2) begin
            cpa_in[k] = PW'(e1x_ff) * PW'(pvy_ff[k]);
            cpb_in[k] = PW'(e1y_ff) * PW'(pvx_ff[k]);
            dpa_in[k] = PW'(pvx_ff[k]) * PW'(e1x_ff);
            dpb_in[k] = PW'(pvy_ff[k]) * PW'(e1y_ff);
         end else begin
            cpa_in[k] = PW'(e2x_ff) * PW'(pvy_ff[k]);
            cpb_in[k] = PW'(e2y_ff) * PW'(pvx_ff[k]);
            dpa_in[k] = PW'(pvx_ff[k]) * PW'(e2x_ff);
            dpb_in[k] = PW'(pvy_ff[k]) * PW'(e2y_ff);
         end
      end
      l1a_in = PW'(e1x_ff) * PW'(e1x_ff);
      l1b_in = PW'(e1y_ff) * PW'(e1y_ff);
      l2a_in = PW'(e2x_ff) * PW'(e2x_ff);
      l2b_in = PW'(e2y_ff) * PW'(e2y_ff);
   end

   always_comb begin
      v3_in = v2_ff;
      for (int k = 0; k < NUM_TESTS; k++) begin
         cross_in[k] = SW'(cpa_ff[k]) - SW'(cpb_ff[k]);
         dot_in[k]   = SW'(dpa_ff[k]) + SW'(dpb_ff[k]);
      end
      len1_in = SW'(l1a_ff) + SW'(l1b_ff);
      len2_in = SW'(l2a_ff) + SW'(l2b_ff);
   end

   always_comb begin
      for (int k = 0; k < NUM_TESTS; k++) begin
         left_flag[k] = (cross_ff[k] > 0);
         if (k < 2) begin
            between_flag[k] = (cross_ff[k] == 0) && (dot_ff[k] > 0) && (dot_ff[k] < len1_ff);
         end else begin
            between_flag[k] = (cross_ff[k] == 0) && (dot_ff[k] > 0) && (dot_ff[k] < len2_ff);
         end
      end
      rsp_valid_in = v3_ff;
      // The flag is cleared between responses.
      rsp_hit_in   = v3_ff && ((|between_flag) ||
                     ((left_flag[0] != left_flag[1]) && (left_flag[2] != left_flag[3])));
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_hit_ff   <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_hit_ff   <= rsp_hit_in;
      end
   end

   // Data registers. They need no reset, because the valid bits qualify them.
   always_ff @(posedge clock) begin
      e1x_ff  <= e1x_in;
      e1y_ff  <= e1y_in;
      e2x_ff  <= e2x_in;
      e2y_ff  <= e2y_in;
      pvx_ff  <= pvx_in;
      pvy_ff  <= pvy_in;
      cpa_ff  <= cpa_in;
      cpb_ff  <= cpb_in;
      dpa_ff  <= dpa_in;
      dpb_ff  <= dpb_in;
      l1a_ff  <= l1a_in;
      l1b_ff  <= l1b_in;
      l2a_ff  <= l2a_in;
      l2b_ff  <= l2b_in;
      cross_ff <= cross_in;
      dot_ff   <= dot_in;
      len1_ff  <= len1_in;
      len2_ff  <= len2_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_intersects = rsp_hit_ff;

endmodule

// ===== sv/segx_checker.sv =====
// Port-level checks for the segment intersection test, bound to the top level.
module segx_checker
   import segx_pkg::*;
#(
   parameter int unsigned COORD_BITS = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic signed [COORD_BITS-1:0] req_ax,
   input logic signed [COORD_BITS-1:0] req_ay,
   input logic signed [COORD_BITS-1:0] req_bx,
   input logic signed [COORD_BITS-1:0] req_by_coord,
   input logic signed [COORD_BITS-1:0] req_cx,
   input logic signed [COORD_BITS-1:0] req_cy,
   input logic signed [COORD_BITS-1:0] req_dx,
   input logic signed [COORD_BITS-1:0] req_dy,
   input logic                         rsp_valid,
   input logic                         rsp_intersects
);

   // Every accepted word yields its response after the PIPE_DEPTH register stages.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_DEPTH rsp_valid)
      else $error("accepted word produced no response");

   // No response appears without a matching accepted word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_DEPTH))
      else $error("response without an accepted word");

   // The flag stays low between responses.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !rsp_intersects)
      else $error("result flag set outside a response");

   // Two degenerate segments can never intersect: no point lies inside either of them,
   // and no point lies to the left of either.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_ax == req_bx) && (req_ay == req_by_coord) &&
       (req_cx == req_dx) && (req_cy == req_dy))
      |-> ##PIPE_DEPTH !rsp_intersects)
      else $error("degenerate segments reported as intersecting");

endmodule

bind segment_intersection_test segx_checker #(.COORD_BITS(COORD_BITS)) u_segx_checker (.*);
